@@ rtl/phfu_pkg.sv @@
// ----------------------------------------------------------------------------
// phfu_pkg
// Types and constants shared by the hazard and forwarding unit.
// ----------------------------------------------------------------------------
package phfu_pkg;

    localparam int IDX_W  = 6;
    localparam int ADDR_W = 32;
    localparam int KIND_W = 2;
    localparam int SEL_W  = 2;

    // address steps for the fetch-stage and decode-stage target matches
    localparam int EARLY_STEP = 4;
    localparam int LATE_STEP  = 8;

    // redirect codes
    localparam logic [KIND_W-1:0] RDR_NONE  = 2'd0;
    localparam logic [KIND_W-1:0] RDR_LATE  = 2'd1;
    localparam logic [KIND_W-1:0] RDR_EARLY = 2'd2;

    // operand source selects
    localparam logic [SEL_W-1:0] SEL_RF  = 2'd0;
    localparam logic [SEL_W-1:0] SEL_EX  = 2'd1;
    localparam logic [SEL_W-1:0] SEL_MEM = 2'd2;
    localparam logic [SEL_W-1:0] SEL_IMM = 2'd3;

    typedef struct packed {
        logic [IDX_W-1:0]  dec_src1;
        logic [IDX_W-1:0]  dec_src2;
        logic [IDX_W-1:0]  ex_dest;
        logic              ex_is_load;
        logic [IDX_W-1:0]  fwd_dest_ex;
        logic [IDX_W-1:0]  fwd_dest_mem;
        logic [KIND_W-1:0] redirect_kind;
        logic [ADDR_W-1:0] target_pc;
        logic [ADDR_W-1:0] decode_pc;
        logic [ADDR_W-1:0] fetch_pc;
    } t_in_item;

    typedef struct packed {
        logic              stall_decode;
        logic              flush_decode;
        logic              flush_fetch;
        logic              pc_override;
        logic [ADDR_W-1:0] next_pc;
        logic [SEL_W-1:0]  src1_sel;
        logic [SEL_W-1:0]  src2_sel;
    } t_out_item;

endpackage

@@ rtl/phfu_in_if.sv @@
// ----------------------------------------------------------------------------
// phfu_in_if
// Valid/ready channel carrying one cycle's hazard inputs.
// ----------------------------------------------------------------------------
interface phfu_in_if
    import phfu_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/phfu_out_if.sv @@
// ----------------------------------------------------------------------------
// phfu_out_if
// Valid/ready channel carrying the hazard and forwarding decisions.
// ----------------------------------------------------------------------------
interface phfu_out_if
    import phfu_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/phfu_core.sv @@
// ----------------------------------------------------------------------------
// phfu_core
// Redirect flushes, PC override, load-use stall and bypass selection.
// ----------------------------------------------------------------------------
module phfu_core
    import phfu_pkg::*;
#(
    parameter int REG_COUNT = 32,
    parameter int PC_WIDTH  = 32
) (
    input  t_in_item  i_item,
    output t_out_item o_result
);

    localparam int PCW = (PC_WIDTH < ADDR_W) ? PC_WIDTH : ADDR_W;
    localparam logic [IDX_W:0] REG_LIMIT = (IDX_W+1)'(REG_COUNT);

    function automatic logic f_is_reg(input logic [IDX_W-1:0] r);
        return {1'b0, r} < REG_LIMIT;
    endfunction

    logic [PCW-1:0]   tgt;
    logic [PCW-1:0]   dpc;
    logic [PCW-1:0]   fpc;
    logic [PCW-1:0]   npc;
    logic             fl_d;
    logic             fl_f;
    logic             ovr;
    logic             v1;
    logic             v2;
    logic             ex_ok;
    logic             fe_ok;
    logic             fm_ok;
    logic [SEL_W-1:0] sel1;
    logic [SEL_W-1:0] sel2;

    assign tgt = i_item.target_pc[PCW-1:0];
    assign dpc = i_item.decode_pc[PCW-1:0];
    assign fpc = i_item.fetch_pc[PCW-1:0];

    always_comb begin
        fl_d = 1'b0;
        fl_f = 1'b0;
        ovr  = 1'b0;
        npc  = '0;
        case (i_item.redirect_kind)
            RDR_LATE: begin
                if (tgt == dpc) begin
                    ovr = 1'b1;
                    npc = dpc + PCW'(LATE_STEP);
                end else begin
                    fl_d = 1'b1;
                    if (tgt == fpc) begin
                        ovr = 1'b1;
                        npc = fpc + PCW'(EARLY_STEP);
                    end else begin
                        fl_f = 1'b1;
                    end
                end
            end
            RDR_EARLY: begin
                if (tgt == fpc) begin
                    ovr = 1'b1;
                    npc = fpc + PCW'(EARLY_STEP);
                end else begin
                    fl_f = 1'b1;
                end
            end
            default: begin
                // no redirect, and the unused code acts the same
            end
        endcase
    end

    // a killed decode stage holds no sources
    assign v1    = f_is_reg(i_item.dec_src1) && !fl_d;
    assign v2    = f_is_reg(i_item.dec_src2) && !fl_d;
    assign ex_ok = f_is_reg(i_item.ex_dest);
    assign fe_ok = f_is_reg(i_item.fwd_dest_ex);
    assign fm_ok = f_is_reg(i_item.fwd_dest_mem);

    always_comb begin
        // execute bypass wins over memory bypass
        if (v1 && fe_ok && i_item.fwd_dest_ex == i_item.dec_src1) begin
            sel1 = SEL_EX;
        end else if (v1 && fm_ok && i_item.fwd_dest_mem == i_item.dec_src1) begin
            sel1 = SEL_MEM;
        end else begin
            sel1 = SEL_RF;
        end

        if (!v2) begin
            sel2 = SEL_IMM;
        end else if (fe_ok && i_item.fwd_dest_ex == i_item.dec_src2) begin
            sel2 = SEL_EX;
        end else if (fm_ok && i_item.fwd_dest_mem == i_item.dec_src2) begin
            sel2 = SEL_MEM;
        end else begin
            sel2 = SEL_RF;
        end
    end

    assign o_result.stall_decode = i_item.ex_is_load && ex_ok &&
                                   ((v1 && i_item.ex_dest == i_item.dec_src1) ||
                                    (v2 && i_item.ex_dest == i_item.dec_src2));
    assign o_result.flush_decode = fl_d;
    assign o_result.flush_fetch  = fl_f;
    assign o_result.pc_override  = ovr;
    assign o_result.next_pc      = ADDR_W'(npc);
    assign o_result.src1_sel     = sel1;
    assign o_result.src2_sel     = sel2;

endmodule

@@ rtl/pipeline_hazard_forward_unit.sv @@
// ----------------------------------------------------------------------------
// pipeline_hazard_forward_unit
// Per-cycle hazard control for a bypassed pipeline.
// ----------------------------------------------------------------------------
// An accepted input word is held in the input register, then in the result
// register, before its result word is valid.
// Throughput: one word per cycle unless o_out stalls; decision logic is one stage.
// Reset: synchronous, active low; clears both stage valid flags only.
// ----------------------------------------------------------------------------
module pipeline_hazard_forward_unit
    import phfu_pkg::*;
#(
    parameter int REG_COUNT = 32,
    parameter int PC_WIDTH  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    phfu_in_if.sink     i_in,
    phfu_out_if.source  o_out
);

    logic      r_v1;
    logic      n_v1;
    t_in_item  r_item;
    logic      r_v2;
    logic      n_v2;
    t_out_item r_out;
    t_out_item comb_out;
    logic      adv2;
    logic      adv1;

    phfu_core #(
        .REG_COUNT (REG_COUNT),
        .PC_WIDTH  (PC_WIDTH)
    ) u_core (
        .i_item   (r_item),
        .o_result (comb_out)
    );

    // the result stage frees up when empty or when its word is taken
    assign adv2       = !r_v2 || o_out.ready;
    assign adv1       = !r_v1 || adv2;
    assign i_in.ready = adv1;

    assign n_v1 = i_in.valid ? 1'b1 : (r_v1 && !adv2);
    assign n_v2 = adv2 ? r_v1 : r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= n_v1;
            end
            r_v2 <= n_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && i_in.valid) begin
            r_item <= i_in.payload;
        end
        if (adv2 && r_v1) begin
            r_out <= comb_out;
        end
    end

    assign o_out.valid   = r_v2;
    assign o_out.payload = r_out;

`ifndef SYNTHESIS
    a_kill_clears_sources: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.payload.flush_decode) |->
        (!o_out.payload.stall_decode && o_out.payload.src1_sel == SEL_RF &&
         o_out.payload.src2_sel == SEL_IMM))
        else $error("killed decode still stalls or forwards");

    a_no_override_zero_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.payload.pc_override) |-> (o_out.payload.next_pc == '0))
        else $error("next_pc non-zero without override");

    a_fetch_flush_or_override: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.payload.flush_decode) |->
        (o_out.payload.flush_fetch != o_out.payload.pc_override))
        else $error("late redirect must flush fetch or override, not both");

    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(i_in.valid && i_in.ready)) |-> r_v1)
        else $error("accepted word lost from input stage");
`endif

endmodule

@@ bench/pipeline_hazard_forward_unit_test.sv @@
// ----------------------------------------------------------------------------
// pipeline_hazard_forward_unit_test
// Self-checking bench for the hazard and forwarding unit. A short table of
// hand-picked cycle words covers the redirect kinds, target matches at the
// top of the address space, the none and immediate indices and the bypass
// priority. It is followed by random words built around small register
// pools, so that stalls and bypass hits are frequent. Every result word is
// checked field by field against its table entry or a local model of the
// decision logic. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module pipeline_hazard_forward_unit_test
    import phfu_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int REG_COUNT      = 32;
    localparam int PC_WIDTH       = 32;
    localparam int PIPE_LATENCY   = 2;
    localparam int RANDOM_WORDS   = 1880;
    localparam int WATCHDOG_LIMIT = 1000;

    // spare redirect encoding, behaves as no redirect
    localparam logic [KIND_W-1:0] RDR_SPARE = 2'd3;

    localparam logic [63:0]       PC_MASK_WIDE = (64'd1 << PC_WIDTH) - 64'd1;
    localparam logic [ADDR_W-1:0] PC_MASK      = PC_MASK_WIDE[ADDR_W-1:0];

    typedef struct {
        t_in_item  word;
        bit        typed;
        t_out_item want;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    phfu_in_if  in_ch ();
    phfu_out_if out_ch ();

    pipeline_hazard_forward_unit #(
        .REG_COUNT (REG_COUNT),
        .PC_WIDTH  (PC_WIDTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_stim_row directed_rows[$];
    t_out_item pending_decisions[$];

    int  error_count    = 0;
    int  words_sent     = 0;
    int  decisions_seen = 0;
    int  stalls_seen    = 0;
    int  dflush_seen    = 0;
    int  fflush_seen    = 0;
    int  override_seen  = 0;
    int  idle_cycles    = 0;
    bit  in_quiet       = 1'b0;
    bit  out_quiet      = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // decision model
    // ------------------------------------------------------------------------
    function automatic bit is_reg(input logic [IDX_W-1:0] r);
        return r < REG_COUNT;
    endfunction

    function automatic bit same_reg(input logic [IDX_W-1:0] a, input logic [IDX_W-1:0] b);
        return is_reg(a) && is_reg(b) && (a == b);
    endfunction

    function automatic logic [SEL_W-1:0] bypass_source(input logic [IDX_W-1:0] src,
                                                       input logic [IDX_W-1:0] dex,
                                                       input logic [IDX_W-1:0] dmem);
        if (same_reg(dex, src)) begin
            return SEL_EX;
        end
        if (same_reg(dmem, src)) begin
            return SEL_MEM;
        end
        return SEL_RF;
    endfunction

    function automatic t_out_item predict_decision(input t_in_item w);
        t_out_item         d;
        logic [IDX_W-1:0]  s1;
        logic [IDX_W-1:0]  s2;
        logic [ADDR_W-1:0] tgt;
        logic [ADDR_W-1:0] dpc;
        logic [ADDR_W-1:0] fpc;
        d   = '0;
        s1  = w.dec_src1;
        s2  = w.dec_src2;
        tgt = w.target_pc & PC_MASK;
        dpc = w.decode_pc & PC_MASK;
        fpc = w.fetch_pc & PC_MASK;
        case (w.redirect_kind)
            RDR_LATE: begin
                if (tgt == dpc) begin
                    d.pc_override = 1'b1;
                    d.next_pc     = (dpc + LATE_STEP) & PC_MASK;
                end else begin
                    d.flush_decode = 1'b1;
                    if (tgt == fpc) begin
                        d.pc_override = 1'b1;
                        d.next_pc     = (fpc + EARLY_STEP) & PC_MASK;
                    end else begin
                        d.flush_fetch = 1'b1;
                    end
                end
            end
            RDR_EARLY: begin
                if (tgt == fpc) begin
                    d.pc_override = 1'b1;
                    d.next_pc     = (fpc + EARLY_STEP) & PC_MASK;
                end else begin
                    d.flush_fetch = 1'b1;
                end
            end
            default: ;
        endcase
        // a killed decode stage carries no sources
        if (d.flush_decode) begin
            s1 = IDX_W'(REG_COUNT);
            s2 = IDX_W'(REG_COUNT);
        end
        d.stall_decode = w.ex_is_load && (same_reg(w.ex_dest, s1) || same_reg(w.ex_dest, s2));
        d.src1_sel     = bypass_source(s1, w.fwd_dest_ex, w.fwd_dest_mem);
        d.src2_sel     = is_reg(s2) ? bypass_source(s2, w.fwd_dest_ex, w.fwd_dest_mem) : SEL_IMM;
        return d;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_in_item hazard_word(input logic [IDX_W-1:0] s1,
                                             input logic [IDX_W-1:0] s2,
                                             input logic [IDX_W-1:0] exd,
                                             input logic ld,
                                             input logic [IDX_W-1:0] fex,
                                             input logic [IDX_W-1:0] fmem,
                                             input logic [KIND_W-1:0] kind,
                                             input logic [ADDR_W-1:0] tgt,
                                             input logic [ADDR_W-1:0] dpc,
                                             input logic [ADDR_W-1:0] fpc);
        t_in_item w;
        w.dec_src1      = s1;
        w.dec_src2      = s2;
        w.ex_dest       = exd;
        w.ex_is_load    = ld;
        w.fwd_dest_ex   = fex;
        w.fwd_dest_mem  = fmem;
        w.redirect_kind = kind;
        w.target_pc     = tgt;
        w.decode_pc     = dpc;
        w.fetch_pc      = fpc;
        return w;
    endfunction

    function automatic t_out_item decision(input logic stl, input logic fd, input logic ff,
                                           input logic ovr, input logic [ADDR_W-1:0] npc,
                                           input logic [SEL_W-1:0] sel1,
                                           input logic [SEL_W-1:0] sel2);
        t_out_item d;
        d.stall_decode = stl;
        d.flush_decode = fd;
        d.flush_fetch  = ff;
        d.pc_override  = ovr;
        d.next_pc      = npc;
        d.src1_sel     = sel1;
        d.src2_sel     = sel2;
        return d;
    endfunction

    task automatic add_row(input t_in_item w, input bit typed, input t_out_item want);
        t_stim_row row;
        row.word  = w;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    // mostly a small pool around base so that indices collide
    function automatic logic [IDX_W-1:0] pick_index(input logic [IDX_W-1:0] base);
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            return base + IDX_W'($urandom_range(0, 3));
        end else if (r < 8) begin
            return IDX_W'($urandom_range(0, REG_COUNT - 1));
        end
        return IDX_W'($urandom_range(REG_COUNT, 63));
    endfunction

    function automatic logic [ADDR_W-1:0] pick_address();
        int r;
        r = $urandom_range(0, 19);
        if (r < 2) begin
            return {ADDR_W{1'b1}} - ADDR_W'($urandom_range(0, 15));
        end else if (r == 2) begin
            return ADDR_W'($urandom_range(0, 15));
        end
        return ADDR_W'($urandom);
    endfunction

    function automatic t_in_item random_hazard_word();
        t_in_item         w;
        logic [IDX_W-1:0] base;
        base            = IDX_W'($urandom_range(0, REG_COUNT - 4));
        w.dec_src1      = pick_index(base);
        w.dec_src2      = pick_index(base);
        w.ex_dest       = pick_index(base);
        w.ex_is_load    = 1'($urandom_range(0, 1));
        w.fwd_dest_ex   = pick_index(base);
        w.fwd_dest_mem  = pick_index(base);
        w.redirect_kind = KIND_W'($urandom_range(0, 3));
        w.decode_pc     = pick_address();
        w.fetch_pc      = ($urandom_range(0, 3) == 0) ? pick_address() : w.decode_pc + 4;
        case ($urandom_range(0, 2))
            0:       w.target_pc = w.decode_pc;
            1:       w.target_pc = w.fetch_pc;
            default: w.target_pc = pick_address();
        endcase
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // input channel
    // ------------------------------------------------------------------------
    task automatic send_word(input t_in_item w, input bit typed, input t_out_item want);
        int gap;
        if ($urandom_range(0, 63) == 0) begin
            in_quiet = !in_quiet;
        end
        gap = in_quiet ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= w;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pending_decisions.push_back(typed ? want : predict_decision(w));
        words_sent++;
    endtask

    // ------------------------------------------------------------------------
    // result channel
    // ------------------------------------------------------------------------
    task automatic compare_field(input string name, input logic [ADDR_W-1:0] want,
                                 input logic [ADDR_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    task automatic check_decision(input t_out_item got);
        t_out_item want;
        if (pending_decisions.size() == 0) begin
            $display("%0t: decision word with none expected, expected none, actual %h",
                     $time, got);
            error_count++;
        end else begin
            want = pending_decisions.pop_front();
            compare_field("stall_decode", ADDR_W'(want.stall_decode),
                          ADDR_W'(got.stall_decode));
            compare_field("flush_decode", ADDR_W'(want.flush_decode),
                          ADDR_W'(got.flush_decode));
            compare_field("flush_fetch",  ADDR_W'(want.flush_fetch),
                          ADDR_W'(got.flush_fetch));
            compare_field("pc_override",  ADDR_W'(want.pc_override),
                          ADDR_W'(got.pc_override));
            compare_field("next_pc",      want.next_pc, got.next_pc);
            compare_field("src1_sel",     ADDR_W'(want.src1_sel), ADDR_W'(got.src1_sel));
            compare_field("src2_sel",     ADDR_W'(want.src2_sel), ADDR_W'(got.src2_sel));
        end
        decisions_seen++;
        stalls_seen   += int'(got.stall_decode);
        dflush_seen   += int'(got.flush_decode);
        fflush_seen   += int'(got.flush_fetch);
        override_seen += int'(got.pc_override);
    endtask

    initial begin : result_sink
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 63) == 0) begin
                out_quiet = !out_quiet;
            end
            stall = out_quiet ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!(out_ch.valid && i_rst_n)) @(posedge i_clk);
            check_decision(out_ch.payload);
        end
    end

    // end the run if neither channel moves a word for too long
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("** pipeline_hazard_forward_unit: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_stim_row row;
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.payload <= '0;

        // nothing to forward, no redirect
        add_row(hazard_word(32, 32, 32, 0, 32, 32, RDR_NONE, 0, 0, 0),
                1, decision(0, 0, 0, 0, 0, SEL_RF, SEL_IMM));
        // register zero everywhere: load-use stall and execute bypass
        add_row(hazard_word(0, 0, 0, 1, 0, 0, RDR_NONE, 32'h100, 32'h104, 32'h108),
                1, decision(1, 0, 0, 0, 0, SEL_EX, SEL_EX));
        // top register from the memory bypass
        add_row(hazard_word(31, 31, 31, 0, 32, 31, RDR_NONE, 32'h10, 32'h20, 32'h24),
                1, decision(0, 0, 0, 0, 0, SEL_MEM, SEL_MEM));
        // none indices never match, not even each other
        add_row(hazard_word(32, 63, 63, 1, 32, 63, RDR_NONE, 32'h0, 32'h4, 32'h8),
                1, decision(0, 0, 0, 0, 0, SEL_RF, SEL_IMM));
        // late branch, no match: both stages killed, sources dropped
        add_row(hazard_word(5, 5, 5, 1, 5, 5, RDR_LATE, 32'h2000, 32'h1000, 32'h1004),
                1, decision(0, 1, 1, 0, 0, SEL_RF, SEL_IMM));
        // late branch hits fetch at the top of the address space
        add_row(hazard_word(5, 6, 6, 1, 5, 6, RDR_LATE,
                            32'hFFFF_FFFC, 32'hFFFF_FFF8, 32'hFFFF_FFFC),
                1, decision(0, 1, 0, 1, 32'h0, SEL_RF, SEL_IMM));
        // late branch hits decode, address wraps, sources survive
        add_row(hazard_word(3, 4, 3, 1, 4, 3, RDR_LATE,
                            32'hFFFF_FFF8, 32'hFFFF_FFF8, 32'hFFFF_FFFC),
                1, decision(1, 0, 0, 1, 32'h0, SEL_MEM, SEL_EX));
        // early branch, no match
        add_row(hazard_word(10, 11, 12, 0, 11, 10, RDR_EARLY, 32'h40, 32'h30, 32'h34),
                0, '0);
        // early branch hits fetch at the very top address
        add_row(hazard_word(1, 2, 9, 0, 9, 9, RDR_EARLY,
                            32'hFFFF_FFFF, 32'h10, 32'hFFFF_FFFF),
                1, decision(0, 0, 0, 1, 32'h3, SEL_RF, SEL_RF));
        // spare redirect code acts as none even when the target matches
        add_row(hazard_word(8, 9, 8, 1, 9, 8, RDR_SPARE, 32'h500, 32'h500, 32'h504),
                1, decision(1, 0, 0, 0, 0, SEL_MEM, SEL_EX));
        // late branch with decode and fetch both at the target
        add_row(hazard_word(20, 21, 22, 1, 20, 21, RDR_LATE,
                            32'h8000_0000, 32'h8000_0000, 32'h8000_0000),
                0, '0);
        // every input bit high
        add_row(hazard_word(63, 63, 63, 1, 63, 63, RDR_SPARE, '1, '1, '1),
                1, decision(0, 0, 0, 0, 0, SEL_RF, SEL_IMM));
        // both bypass registers match: execute wins
        add_row(hazard_word(7, 7, 30, 0, 7, 7, RDR_NONE, 32'h0, 32'h0, 32'h0),
                1, decision(0, 0, 0, 0, 0, SEL_EX, SEL_EX));
        // load-use on the second source only
        add_row(hazard_word(14, 15, 15, 1, 16, 15, RDR_NONE, 32'h1234, 32'h5678, 32'h9ABC),
                0, '0);
        add_row(hazard_word(0, 31, 31, 1, 31, 0, RDR_EARLY, 32'h0, 32'h0, 32'h4),
                0, '0);
        add_row(hazard_word(21, 42, 21, 1, 42, 21, RDR_LATE,
                            32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA),
                0, '0);
        add_row(hazard_word(42, 21, 42, 0, 21, 42, RDR_EARLY,
                            32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5554),
                0, '0);
        add_row(hazard_word(31, 0, 0, 1, 0, 31, RDR_NONE,
                            32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA),
                0, '0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_word(row.word, row.typed, row.want);
        end
        repeat (RANDOM_WORDS) send_word(random_hazard_word(), 1'b0, '0);
        in_ch.valid <= 1'b0;

        // drain, then hold a little longer to catch stray result words
        while (pending_decisions.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 8) @(posedge i_clk);

        $display("Sent %0d cycle words (%0d from the table), checked %0d decision words.",
                 words_sent, directed_rows.size(), decisions_seen);
        $display("Results held %0d stalls, %0d decode and %0d fetch flushes, %0d overrides.",
                 stalls_seen, dflush_seen, fflush_seen, override_seen);
        if (error_count == 0) begin
            $display("** pipeline_hazard_forward_unit: PASSED **");
        end else begin
            $display("%0d mismatches", error_count);
            $display("** pipeline_hazard_forward_unit: FAILED **");
        end
        $finish;
    end

endmodule

@@ pipeline_hazard_forward_unit.f @@
rtl/phfu_pkg.sv
rtl/phfu_in_if.sv
rtl/phfu_out_if.sv
rtl/phfu_core.sv
rtl/pipeline_hazard_forward_unit.sv
bench/pipeline_hazard_forward_unit_test.sv
